// ===== hdl/fsgt_pkg.sv =====
`timescale 1ns / 1ps

package fsgt_pkg;

  localparam int CfgDataWidth = 32;
  localparam int CfgIndexWidth = 3;

  localparam logic [CfgIndexWidth-1:0] REG_TEMP_LIMIT = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_VOLTAGE_LIMIT = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_MAX_CURRENT = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_FAULT_TIMEOUT = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_BUTTON_TIMEOUT = 3'd4;

  localparam logic signed [15:0] TEMP_LIMIT_RESET = 16'sd800;
  localparam logic [15:0] VOLTAGE_LIMIT_RESET = 16'd2800;
  localparam logic [15:0] MAX_CURRENT_RESET = 16'd10000;
  localparam logic [31:0] FAULT_TIMEOUT_RESET = 32'd1000;
  localparam logic [31:0] BUTTON_TIMEOUT_RESET = 32'd3000;

  typedef enum logic [2:0] {
    FAULT_NONE = 3'd0,
    FAULT_BUTTON = 3'd1,
    FAULT_TEMP = 3'd2,
    FAULT_CURR = 3'd3,
    FAULT_VOLT = 3'd4
  } fault_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_EXTERNAL = 3'd1,
    ERR_BUTTON = 3'd2,
    ERR_TEMP = 3'd3,
    ERR_CURR = 3'd4,
    ERR_VOLT = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    LED_KEEP = 2'd0,
    LED_RED = 2'd1,
    LED_BLINK = 2'd2,
    LED_PREV = 2'd3
  } led_t;

  typedef struct packed {
    logic signed [15:0] temp_limit;
    logic [15:0] voltage_limit;
    logic [15:0] max_current;
    logic [31:0] fault_timeout_ms;
    logic [31:0] button_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0] ext_error_code;
    logic button_press;
    logic button_released;
    logic sim_running;
    logic skip_tick;
    logic signed [15:0] heat_sink_temp;
    logic signed [15:0] current_sample;
    logic [15:0] left_voltage;
    logic [15:0] right_voltage;
  } tick_t;

  typedef struct packed {
    fault_t warning_code;
    err_t error_code;
    logic [7:0] forwarded_error;
    logic stop_request;
    logic reset_request;
    led_t led_mode;
    fault_t active_fault;
  } result_t;

endpackage

// ===== hdl/fault_supervisor_grace_timeout_unit.sv =====
`timescale 1ns / 1ps

// Fault supervisor with grace timeouts for a cell discharge bench.
// Input channel (in_valid / in_ready) carries one supervision tick per item:
// timestamp, pending external error, button flags, run and skip flags and
// four measurements. Output channel (out_valid / out_ready) returns exactly
// one result item per tick: warning, error, forwarded error, stop and reset
// requests, LED mode and the active fault after the tick.
// The tick is captured in an input register, evaluated against the fault
// state, and the result lands in an output register that drives out_valid.
// Throughput is one item per cycle while the receiver takes results; the
// single elapsed-time subtract and compare sets the critical path.
// When the receiver stalls, the result is held and the input register still
// takes one more item; after that in_ready drops until the output drains.
// Reset clears the fault state (no active fault, start time zero), loads the
// register defaults and empties both stages. Configuration writes through
// cfg_write / cfg_index / cfg_data take effect at the next edge and are
// expected only while no item is in flight.

module fault_supervisor_grace_timeout_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [fsgt_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [fsgt_pkg::CfgDataWidth-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [31:0] now_ms,
  input  logic [7:0] ext_error_code,
  input  logic button_press,
  input  logic button_released,
  input  logic sim_running,
  input  logic skip_tick,
  input  logic signed [15:0] heat_sink_temp,
  input  logic signed [15:0] current_sample,
  input  logic [15:0] left_voltage,
  input  logic [15:0] right_voltage,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] warning_code,
  output logic [2:0] error_code,
  output logic [7:0] forwarded_error,
  output logic stop_request,
  output logic reset_request,
  output logic [1:0] led_mode,
  output logic [2:0] active_fault
);

  fsgt_pkg::cfg_t cfg;
  fsgt_pkg::tick_t tick;
  logic tick_valid;
  logic advance;
  fsgt_pkg::fault_t active_event;
  fsgt_pkg::fault_t active_event_next;
  logic [31:0] event_start_ms;
  logic [31:0] event_start_ms_next;
  fsgt_pkg::result_t result_next;
  fsgt_pkg::result_t result;

  fsgt_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  fsgt_eval u_eval (
    .cfg(cfg),
    .tick(tick),
    .active_event(active_event),
    .event_start_ms(event_start_ms),
    .active_event_next(active_event_next),
    .event_start_ms_next(event_start_ms_next),
    .result(result_next)
  );

  assign advance = tick_valid && (!out_valid || out_ready);
  assign in_ready = !tick_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick.now_ms <= now_ms;
      tick.ext_error_code <= ext_error_code;
      tick.button_press <= button_press;
      tick.button_released <= button_released;
      tick.sim_running <= sim_running;
      tick.skip_tick <= skip_tick;
      tick.heat_sink_temp <= heat_sink_temp;
      tick.current_sample <= current_sample;
      tick.left_voltage <= left_voltage;
      tick.right_voltage <= right_voltage;
    end
  end

  // fault state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_event <= fsgt_pkg::FAULT_NONE;
      event_start_ms <= '0;
    end else if (advance) begin
      active_event <= active_event_next;
      event_start_ms <= event_start_ms_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign warning_code = result.warning_code;
  assign error_code = result.error_code;
  assign forwarded_error = result.forwarded_error;
  assign stop_request = result.stop_request;
  assign reset_request = result.reset_request;
  assign led_mode = result.led_mode;
  assign active_fault = result.active_fault;

  a_stop_ends_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_request |-> led_mode == fsgt_pkg::LED_RED
      && active_fault == fsgt_pkg::FAULT_NONE)
    else $error("stop request without red led and cleared fault");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("evaluated item did not reach the output register");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(active_event) && $stable(event_start_ms))
    else $error("fault state changed without an item");

  a_state_matches_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> active_fault == active_event)
    else $error("reported fault differs from stored fault");

  a_external_forwarded: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == fsgt_pkg::ERR_EXTERNAL |-> forwarded_error != 8'd0)
    else $error("external error forwarded as zero");

endmodule

// ===== hdl/fsgt_cfg.sv =====
`timescale 1ns / 1ps

module fsgt_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [fsgt_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [fsgt_pkg::CfgDataWidth-1:0] cfg_data,
  output fsgt_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_limit <= fsgt_pkg::TEMP_LIMIT_RESET;
      cfg.voltage_limit <= fsgt_pkg::VOLTAGE_LIMIT_RESET;
      cfg.max_current <= fsgt_pkg::MAX_CURRENT_RESET;
      cfg.fault_timeout_ms <= fsgt_pkg::FAULT_TIMEOUT_RESET;
      cfg.button_timeout_ms <= fsgt_pkg::BUTTON_TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fsgt_pkg::REG_TEMP_LIMIT: cfg.temp_limit <= signed'(cfg_data[15:0]);
        fsgt_pkg::REG_VOLTAGE_LIMIT: cfg.voltage_limit <= cfg_data[15:0];
        fsgt_pkg::REG_MAX_CURRENT: cfg.max_current <= cfg_data[15:0];
        fsgt_pkg::REG_FAULT_TIMEOUT: cfg.fault_timeout_ms <= cfg_data[31:0];
        fsgt_pkg::REG_BUTTON_TIMEOUT: cfg.button_timeout_ms <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/fsgt_eval.sv =====
`timescale 1ns / 1ps

module fsgt_eval (
  input  fsgt_pkg::cfg_t cfg,
  input  fsgt_pkg::tick_t tick,
  input  fsgt_pkg::fault_t active_event,
  input  logic [31:0] event_start_ms,
  output fsgt_pkg::fault_t active_event_next,
  output logic [31:0] event_start_ms_next,
  output fsgt_pkg::result_t result
);

  logic [16:0] magnitude;
  logic temp_high;
  logic curr_high;
  logic volt_low;
  logic [31:0] elapsed;
  logic [31:0] limit;
  logic timed_out;
  fsgt_pkg::fault_t ev1;
  logic [31:0] start1;

  assign magnitude = tick.current_sample[15]
                     ? 17'(-{tick.current_sample[15], tick.current_sample})
                     : {1'b0, tick.current_sample};
  assign temp_high = tick.heat_sink_temp > cfg.temp_limit;
  assign curr_high = magnitude > {1'b0, cfg.max_current};
  assign volt_low = (tick.left_voltage < cfg.voltage_limit)
                    || (tick.right_voltage < cfg.voltage_limit);

  // button press restarts the event before any check
  assign ev1 = tick.button_press ? fsgt_pkg::FAULT_BUTTON : active_event;
  assign start1 = tick.button_press ? tick.now_ms : event_start_ms;

  // one shared elapsed-time compare
  assign elapsed = tick.now_ms - start1;
  assign limit = (ev1 == fsgt_pkg::FAULT_BUTTON) ? cfg.button_timeout_ms
                                                  : cfg.fault_timeout_ms;
  assign timed_out = elapsed > limit;

  always_comb begin
    fsgt_pkg::fault_t ev;
    logic done;
    ev = active_event;
    done = 1'b0;
    result = '0;
    result.warning_code = fsgt_pkg::FAULT_NONE;
    result.error_code = fsgt_pkg::ERR_NONE;
    result.led_mode = fsgt_pkg::LED_KEEP;
    event_start_ms_next = event_start_ms;

    if (tick.ext_error_code != 8'd0) begin
      result.error_code = fsgt_pkg::ERR_EXTERNAL;
      result.forwarded_error = tick.ext_error_code;
      result.led_mode = fsgt_pkg::LED_RED;
      result.stop_request = 1'b1;
      ev = fsgt_pkg::FAULT_NONE;
    end else begin
      ev = ev1;
      event_start_ms_next = start1;
      if (tick.button_press) begin
        result.reset_request = !tick.sim_running;
        result.warning_code = fsgt_pkg::FAULT_BUTTON;
        result.led_mode = fsgt_pkg::LED_BLINK;
      end
      if (tick.sim_running && !tick.skip_tick) begin
        if (ev1 == fsgt_pkg::FAULT_BUTTON) begin
          if (timed_out) begin
            result.error_code = fsgt_pkg::ERR_BUTTON;
            result.led_mode = fsgt_pkg::LED_RED;
            result.stop_request = 1'b1;
            ev = fsgt_pkg::FAULT_NONE;
          end else if (tick.button_released) begin
            result.led_mode = fsgt_pkg::LED_PREV;
            ev = fsgt_pkg::FAULT_NONE;
          end
        end else begin
          // temperature check
          if (temp_high) begin
            done = 1'b1;
            if (ev == fsgt_pkg::FAULT_NONE) begin
              result.warning_code = fsgt_pkg::FAULT_TEMP;
              result.led_mode = fsgt_pkg::LED_BLINK;
              ev = fsgt_pkg::FAULT_TEMP;
              event_start_ms_next = tick.now_ms;
            end else if (ev == fsgt_pkg::FAULT_TEMP && timed_out) begin
              result.error_code = fsgt_pkg::ERR_TEMP;
              result.led_mode = fsgt_pkg::LED_RED;
              result.stop_request = 1'b1;
              ev = fsgt_pkg::FAULT_NONE;
            end
          end else if (ev == fsgt_pkg::FAULT_TEMP) begin
            result.led_mode = fsgt_pkg::LED_PREV;
            ev = fsgt_pkg::FAULT_NONE;
          end
          // current check
          if (!done) begin
            if (curr_high) begin
              done = 1'b1;
              if (ev == fsgt_pkg::FAULT_NONE) begin
                result.warning_code = fsgt_pkg::FAULT_CURR;
                result.led_mode = fsgt_pkg::LED_BLINK;
                ev = fsgt_pkg::FAULT_CURR;
                event_start_ms_next = tick.now_ms;
              end else if (ev == fsgt_pkg::FAULT_CURR && timed_out) begin
                result.error_code = fsgt_pkg::ERR_CURR;
                result.led_mode = fsgt_pkg::LED_RED;
                result.stop_request = 1'b1;
                ev = fsgt_pkg::FAULT_NONE;
              end
            end else if (ev == fsgt_pkg::FAULT_CURR) begin
              result.led_mode = fsgt_pkg::LED_PREV;
              ev = fsgt_pkg::FAULT_NONE;
            end
          end
          // voltage check
          if (!done) begin
            if (volt_low) begin
              if (ev == fsgt_pkg::FAULT_NONE) begin
                result.warning_code = fsgt_pkg::FAULT_VOLT;
                result.led_mode = fsgt_pkg::LED_BLINK;
                ev = fsgt_pkg::FAULT_VOLT;
                event_start_ms_next = tick.now_ms;
              end else if (ev == fsgt_pkg::FAULT_VOLT && timed_out) begin
                result.error_code = fsgt_pkg::ERR_VOLT;
                result.led_mode = fsgt_pkg::LED_RED;
                result.stop_request = 1'b1;
                ev = fsgt_pkg::FAULT_NONE;
              end
            end else if (ev == fsgt_pkg::FAULT_VOLT) begin
              result.led_mode = fsgt_pkg::LED_PREV;
              ev = fsgt_pkg::FAULT_NONE;
            end
          end
        end
      end
    end

    active_event_next = ev;
    result.active_fault = ev;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import fsgt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [CfgIndexWidth-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  tick_t drv_tick = '0;

  logic [2:0] warning_code;
  logic [2:0] error_code;
  logic [7:0] forwarded_error;
  logic stop_request;
  logic reset_request;
  logic [1:0] led_mode;
  logic [2:0] active_fault;

  // supervisor model state and limits
  fault_t fault_state = FAULT_NONE;
  logic [31:0] fault_start_ms = '0;
  logic signed [15:0] lim_temp = TEMP_LIMIT_RESET;
  logic [15:0] lim_volt = VOLTAGE_LIMIT_RESET;
  logic [15:0] lim_curr = MAX_CURRENT_RESET;
  logic [31:0] grace_fault_ms = FAULT_TIMEOUT_RESET;
  logic [31:0] grace_button_ms = BUTTON_TIMEOUT_RESET;

  tick_t tick_backlog[$];
  result_t predicted_status[$];
  int ticks_issued = 0;
  int statuses_seen = 0;
  int mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  result_t got;
  result_t want;

  // stimulus sequence state
  logic [31:0] clock_ms = '0;
  bit hot = 1'b0;
  bit overcur = 1'b0;
  bit undervolt = 1'b0;

  fault_supervisor_grace_timeout_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .now_ms(drv_tick.now_ms),
    .ext_error_code(drv_tick.ext_error_code),
    .button_press(drv_tick.button_press),
    .button_released(drv_tick.button_released),
    .sim_running(drv_tick.sim_running),
    .skip_tick(drv_tick.skip_tick),
    .heat_sink_temp(drv_tick.heat_sink_temp),
    .current_sample(drv_tick.current_sample),
    .left_voltage(drv_tick.left_voltage),
    .right_voltage(drv_tick.right_voltage),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .warning_code(warning_code),
    .error_code(error_code),
    .forwarded_error(forwarded_error),
    .stop_request(stop_request),
    .reset_request(reset_request),
    .led_mode(led_mode),
    .active_fault(active_fault)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void fault_begin(inout result_t r, input fault_t f, input logic [31:0] now);
    r.led_mode = LED_BLINK;
    fault_state = f;
    fault_start_ms = now;
  endfunction

  function automatic void fault_end(inout result_t r);
    r.led_mode = LED_PREV;
    fault_state = FAULT_NONE;
  endfunction

  function automatic void fault_trip(inout result_t r);
    r.led_mode = LED_RED;
    r.stop_request = 1'b1;
    fault_state = FAULT_NONE;
  endfunction

  function automatic bit grace_over(input logic [31:0] now, input logic [31:0] grace);
    logic [31:0] held;
    held = now - fault_start_ms;
    return held > grace;
  endfunction

  function automatic bit measure_check(inout result_t r, input fault_t f, input err_t e,
                                       input bit cond, input logic [31:0] now);
    if (cond) begin
      if (fault_state == FAULT_NONE) begin
        r.warning_code = f;
        fault_begin(r, f, now);
      end else if (fault_state == f && grace_over(now, grace_fault_ms)) begin
        r.error_code = e;
        fault_trip(r);
      end
      return 1'b1;
    end
    if (fault_state == f) fault_end(r);
    return 1'b0;
  endfunction

  function automatic result_t supervise_tick(input tick_t t);
    result_t r;
    int temp_v;
    int cur_mag;
    bit volt_low;
    r.warning_code = FAULT_NONE;
    r.error_code = ERR_NONE;
    r.forwarded_error = 8'd0;
    r.stop_request = 1'b0;
    r.reset_request = 1'b0;
    r.led_mode = LED_KEEP;
    r.active_fault = FAULT_NONE;
    temp_v = int'($signed(t.heat_sink_temp));
    cur_mag = int'($signed(t.current_sample));
    if (cur_mag < 0) cur_mag = -cur_mag;
    volt_low = (t.left_voltage < lim_volt) || (t.right_voltage < lim_volt);
    if (t.ext_error_code != 8'd0) begin
      r.error_code = ERR_EXTERNAL;
      r.forwarded_error = t.ext_error_code;
      fault_trip(r);
    end else begin
      if (t.button_press) begin
        r.reset_request = !t.sim_running;
        r.warning_code = FAULT_BUTTON;
        fault_begin(r, FAULT_BUTTON, t.now_ms);
      end
      if (t.sim_running && !t.skip_tick) begin
        if (fault_state == FAULT_BUTTON) begin
          if (grace_over(t.now_ms, grace_button_ms)) begin
            r.error_code = ERR_BUTTON;
            fault_trip(r);
          end else if (t.button_released) begin
            fault_end(r);
          end
        end else if (!measure_check(r, FAULT_TEMP, ERR_TEMP, temp_v > int'(lim_temp),
                                    t.now_ms)) begin
          if (!measure_check(r, FAULT_CURR, ERR_CURR, cur_mag > int'(lim_curr), t.now_ms))
            void'(measure_check(r, FAULT_VOLT, ERR_VOLT, volt_low, t.now_ms));
        end
      end
    end
    r.active_fault = fault_state;
    return r;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int roll;
    int mag;
    roll = $urandom_range(0, 99);
    if (roll < 60) clock_ms += $urandom_range(0, 40);
    else if (roll < 75) clock_ms += grace_fault_ms + $urandom_range(0, 2) - 1;
    else if (roll < 85) clock_ms += grace_button_ms + $urandom_range(0, 2) - 1;
    else if (roll < 95) clock_ms += $urandom_range(0, 1500);
    else clock_ms = $urandom();
    if ($urandom_range(0, 99) < 12) hot = !hot;
    if ($urandom_range(0, 99) < 12) overcur = !overcur;
    if ($urandom_range(0, 99) < 12) undervolt = !undervolt;
    t.now_ms = clock_ms;
    t.ext_error_code = ($urandom_range(0, 99) < 3) ? 8'($urandom_range(1, 255)) : 8'd0;
    t.button_press = $urandom_range(0, 99) < 7;
    t.button_released = 1'($urandom_range(0, 1));
    t.sim_running = $urandom_range(0, 99) < 88;
    t.skip_tick = $urandom_range(0, 99) < 10;
    if ($urandom_range(0, 9) == 0) t.heat_sink_temp = 16'($urandom());
    else if (hot) t.heat_sink_temp = lim_temp + 16'($urandom_range(1, 300));
    else t.heat_sink_temp = lim_temp - 16'($urandom_range(0, 300));
    if (overcur) mag = int'(lim_curr) + int'($urandom_range(1, 300));
    else mag = int'($urandom_range(0, lim_curr));
    if (mag > 32768) mag = 32768;
    if ($urandom_range(0, 1)) mag = -mag;
    t.current_sample = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'(mag);
    if ($urandom_range(0, 9) == 0) begin
      t.left_voltage = 16'($urandom());
      t.right_voltage = 16'($urandom());
    end else begin
      t.left_voltage = lim_volt + 16'($urandom_range(0, 300));
      t.right_voltage = lim_volt + 16'($urandom_range(0, 300));
      if (undervolt) begin
        roll = $urandom_range(0, 2);
        if (roll != 1) t.left_voltage = lim_volt - 16'($urandom_range(1, 300));
        if (roll != 0) t.right_voltage = lim_volt - 16'($urandom_range(1, 300));
      end
    end
    return t;
  endfunction

  task automatic add_tick(input logic [31:0] now, input logic [7:0] ext, input bit press,
                          input bit released, input bit running, input bit skip,
                          input logic [15:0] temp, input logic [15:0] cur,
                          input logic [15:0] lv, input logic [15:0] rv);
    tick_t t;
    t.now_ms = now;
    t.ext_error_code = ext;
    t.button_press = press;
    t.button_released = released;
    t.sim_running = running;
    t.skip_tick = skip;
    t.heat_sink_temp = temp;
    t.current_sample = cur;
    t.left_voltage = lv;
    t.right_voltage = rv;
    tick_backlog.push_back(t);
    ticks_issued++;
  endtask

  task automatic run_ticks(input int n);
    repeat (n) begin
      tick_backlog.push_back(random_tick());
      ticks_issued++;
    end
    wait (statuses_seen == ticks_issued);
    @(posedge clk);
  endtask

  task automatic set_reg(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TEMP_LIMIT: lim_temp = val[15:0];
      REG_VOLTAGE_LIMIT: lim_volt = val[15:0];
      REG_MAX_CURRENT: lim_curr = val[15:0];
      REG_FAULT_TIMEOUT: grace_fault_ms = val;
      REG_BUTTON_TIMEOUT: grace_button_ms = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] temp, input logic [15:0] volt,
                            input logic [15:0] cur, input logic [31:0] fault_ms,
                            input logic [31:0] button_ms);
    set_reg(REG_TEMP_LIMIT, {16'($urandom()), temp});
    set_reg(REG_VOLTAGE_LIMIT, {16'($urandom()), volt});
    set_reg(REG_MAX_CURRENT, {16'($urandom()), cur});
    set_reg(REG_FAULT_TIMEOUT, fault_ms);
    set_reg(REG_BUTTON_TIMEOUT, button_ms);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_status.push_back(supervise_tick(drv_tick));
      end
      if (!in_valid || in_ready) begin
        if (tick_backlog.size() > 0 && (steady_in || $urandom_range(0, 99) >= 34)) begin
          drv_tick <= tick_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_out || $urandom_range(0, 99) >= 34;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      statuses_seen++;
      got = {warning_code, error_code, forwarded_error, stop_request, reset_request,
             led_mode, active_fault};
      if (predicted_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected item from block: %h", got);
      end else begin
        want = predicted_status.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected warn %0d err %0d fwd %0d stop %0d rst %0d led %0d fault %0d",
                     want.warning_code, want.error_code, want.forwarded_error,
                     want.stop_request, want.reset_request, want.led_mode, want.active_fault);
            $display("          got warn %0d err %0d fwd %0d stop %0d rst %0d led %0d fault %0d",
                     got.warning_code, got.error_code, got.forwarded_error,
                     got.stop_request, got.reset_request, got.led_mode, got.active_fault);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: temp 800, volt 2800, current 10000, grace 1000 / 3000
    add_tick(32'd0, 8'd0, 0, 0, 0, 0, 16'd0, 16'd0, 16'd0, 16'd0);
    add_tick(32'd10, 8'd255, 0, 0, 1, 0, 16'h7fff, 16'h8000, 16'd0, 16'd0);
    add_tick(32'd20, 8'd1, 1, 1, 1, 1, 16'd0, 16'd0, 16'hffff, 16'hffff);
    add_tick(32'd30, 8'd0, 1, 0, 0, 0, 16'd0, 16'd0, 16'd5000, 16'd5000);
    add_tick(32'd40, 8'd0, 1, 1, 1, 0, 16'd0, 16'd0, 16'd5000, 16'd5000);
    add_tick(32'd50, 8'd0, 1, 0, 1, 0, 16'd0, 16'd0, 16'd5000, 16'd5000);
    add_tick(32'd3050, 8'd0, 0, 0, 1, 0, 16'd0, 16'd0, 16'd5000, 16'd5000);
    add_tick(32'd3051, 8'd0, 0, 0, 1, 0, 16'd0, 16'd0, 16'd5000, 16'd5000);
    add_tick(32'd3100, 8'd0, 0, 1, 1, 0, 16'h7fff, 16'd0, 16'd5000, 16'd5000);
    add_tick(32'd3200, 8'd0, 0, 1, 1, 0, 16'd0, 16'h8000, 16'd5000, 16'd5000);
    add_tick(32'd3300, 8'd0, 0, 1, 1, 0, 16'd900, 16'd0, 16'd5000, 16'd5000);
    add_tick(32'd4101, 8'd0, 0, 1, 1, 0, 16'd900, 16'd0, 16'd5000, 16'd5000);
    add_tick(32'd4200, 8'd0, 0, 1, 1, 0, 16'd0, 16'h8000, 16'd5000, 16'd5000);
    add_tick(32'd4300, 8'd0, 0, 1, 1, 1, 16'd0, 16'd0, 16'd5000, 16'd5000);
    add_tick(32'd4400, 8'd0, 0, 1, 0, 0, 16'd0, 16'd0, 16'd5000, 16'd5000);
    add_tick(32'd4500, 8'd0, 0, 1, 1, 0, 16'd0, 16'd0, 16'd0, 16'd5000);
    add_tick(32'd4600, 8'd0, 0, 1, 1, 0, 16'd0, 16'd0, 16'd5000, 16'd0);
    add_tick(32'd5200, 8'd0, 0, 1, 1, 0, 16'd0, 16'd0, 16'd5000, 16'd2799);
    add_tick(32'd5201, 8'd0, 0, 1, 1, 0, 16'd800, 16'd10000, 16'd2800, 16'd2800);
    add_tick(32'hfffffff0, 8'd0, 0, 1, 1, 0, 16'd801, 16'd0, 16'd2800, 16'd2800);
    add_tick(32'h000003d8, 8'd0, 0, 1, 1, 0, 16'd801, 16'd0, 16'd2800, 16'd2800);
    add_tick(32'h000003d9, 8'd0, 0, 1, 1, 0, 16'd801, 16'd0, 16'd2800, 16'd2800);
    add_tick(32'h00000400, 8'd0, 0, 1, 1, 0, 16'd801, 16'hd8ef, 16'd2800, 16'd2800);
    add_tick(32'h00000410, 8'd0, 1, 0, 1, 0, 16'd801, 16'd0, 16'd2800, 16'd2800);
    add_tick(32'h00000420, 8'd128, 0, 0, 1, 0, 16'd0, 16'd0, 16'd2800, 16'd2800);
    run_ticks(0);
    run_ticks(100);

    set_limits(16'h8000, 16'hffff, 16'd0, 32'd0, 32'd0);
    set_reg(REG_SPARE_LO, $urandom());
    set_reg(REG_SPARE_HI, $urandom());
    run_ticks(60);

    set_limits(16'h7fff, 16'd0, 16'd32768, 32'hffffffff, 32'hffffffff);
    run_ticks(60);

    for (int phase = 0; phase < 4; phase++) begin
      set_limits(16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 32768)),
                 ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3000),
                 ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3000));
      steady_in = (phase == 1) || (phase == 2);
      steady_out = (phase == 1);
      if (phase == 2) hold_requests++;
      run_ticks(90);
    end

    set_limits(16'd800, 16'd2800, 16'd10000, 32'd1000, 32'd3000);
    steady_in = 1'b1;
    steady_out = 1'b0;
    hold_requests++;
    run_ticks(100);
    steady_in = 1'b0;

    wait (statuses_seen == ticks_issued);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_status.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
